// ----- src/aesr_pkg.sv -----
// ----------------------------------------------------------------------------
// AES round package
// Request and result types, lane control, the S-box table and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesr_pkg;

  localparam int unsigned NumCols = 4;

  // One request: four state columns and four round key words
  typedef struct packed {
    logic [31:0] state_col0;
    logic [31:0] state_col1;
    logic [31:0] state_col2;
    logic [31:0] state_col3;
    logic [31:0] key_col0;
    logic [31:0] key_col1;
    logic [31:0] key_col2;
    logic [31:0] key_col3;
  } aesr_in_t;

  // One result: four new columns
  typedef struct packed {
    logic [31:0] out_col0;
    logic [31:0] out_col1;
    logic [31:0] out_col2;
    logic [31:0] out_col3;
  } aesr_out_t;

  // Pipeline load enables shared by all lanes
  typedef struct packed {
    logic sub_en;
    logic mix_en;
  } aesr_ctrl_t;

  // Forward S-box
  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Reduction constant of x^8+x^4+x^3+x+1
  localparam logic [7:0] GfPoly = 8'h1b;

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    gf_double = {b[6:0], 1'b0} ^ (b[7] ? GfPoly : 8'h00);
  endfunction

endpackage

// ----- src/aes_encrypt_round.sv -----
// ----------------------------------------------------------------------------
// AES encryption round
// One full forward AES round (SubBytes, ShiftRows, MixColumns, AddRoundKey).
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid_i / in_ready_o / in_req_i carries four state
//   columns and four round key words. Result channel out_valid_o /
//   out_ready_i / out_rsp_o returns the four new columns. A keyless round
//   is a request with all key words zero.
//   Four column lanes work side by side; ShiftRows is the wiring that feeds
//   each lane, and the lane outputs are gathered into one result.
//   The S-box stage registers the request; the MixColumns stage after it is
//   the output register and loads once it is free or its result is taken.
//   Throughput: one request per cycle while out_ready_i is high; each stage
//   is one register deep.
//   Stall: when out_ready_i is low the result holds; the S-box stage still
//   takes one more request, after which in_ready_o drops.
//   Reset: both stage valid flags clear; no request is in flight.
// ----------------------------------------------------------------------------
module aes_encrypt_round
  import aesr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  aesr_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output aesr_out_t out_rsp_o
);

  logic        sub_valid_q, sub_valid_d;
  logic        mix_valid_q, mix_valid_d;
  logic        mix_ready;
  aesr_ctrl_t  ctrl;
  logic [31:0] state [NumCols];
  logic [31:0] key   [NumCols];
  logic [31:0] lane_in  [NumCols];
  logic [31:0] lane_out [NumCols];

  // Pipeline flow control
  assign mix_ready   = !mix_valid_q || out_ready_i;
  assign in_ready_o  = !sub_valid_q || mix_ready;
  assign ctrl.sub_en = in_valid_i && in_ready_o;
  assign ctrl.mix_en = sub_valid_q && mix_ready;

  assign sub_valid_d = ctrl.sub_en ? 1'b1 : (ctrl.mix_en ? 1'b0 : sub_valid_q);
  assign mix_valid_d = ctrl.mix_en ? 1'b1 : (out_ready_i ? 1'b0 : mix_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_valid_q <= 1'b0;
      mix_valid_q <= 1'b0;
    end else begin
      sub_valid_q <= sub_valid_d;
      mix_valid_q <= mix_valid_d;
    end
  end

  // Unpack the request
  assign state[0] = in_req_i.state_col0;
  assign state[1] = in_req_i.state_col1;
  assign state[2] = in_req_i.state_col2;
  assign state[3] = in_req_i.state_col3;
  assign key[0]   = in_req_i.key_col0;
  assign key[1]   = in_req_i.key_col1;
  assign key[2]   = in_req_i.key_col2;
  assign key[3]   = in_req_i.key_col3;

  // ShiftRows: row r of lane c comes from column (c + r) mod 4
  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      for (int r = 0; r < 4; r++) begin
        lane_in[c][8*r +: 8] = state[(c + r) % NumCols][8*r +: 8];
      end
    end
  end

  // Column lanes
  for (genvar g = 0; g < NumCols; g++) begin : g_lane
    aesr_lane u_lane (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .col_i (lane_in[g]),
      .key_i (key[g]),
      .col_o (lane_out[g])
    );
  end

  // Gather lane results
  assign out_rsp_o.out_col0 = lane_out[0];
  assign out_rsp_o.out_col1 = lane_out[1];
  assign out_rsp_o.out_col2 = lane_out[2];
  assign out_rsp_o.out_col3 = lane_out[3];
  assign out_valid_o        = mix_valid_q;

  // Assertions
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!sub_valid_q || !mix_valid_q || out_ready_i))
    else $error("in_ready_o does not follow stage occupancy");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> sub_valid_q)
    else $error("accepted request missing from S-box stage");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_valid_q && (!mix_valid_q || out_ready_i)) |=> out_valid_o)
    else $error("S-box stage advanced without a result");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_valid_q && mix_valid_q && !out_ready_i) |=> (sub_valid_q && mix_valid_q))
    else $error("stalled pipeline lost a request");

endmodule

// ----- src/aesr_lane.sv -----
// ----------------------------------------------------------------------------
// AES round column lane
// SubBytes on one shifted column, then MixColumns and round key addition.
// ----------------------------------------------------------------------------
module aesr_lane
  import aesr_pkg::*;
(
  input  logic        clk_i,
  input  aesr_ctrl_t  ctrl_i,
  input  logic [31:0] col_i,   // row r in bits 8r+7..8r, already row shifted
  input  logic [31:0] key_i,
  output logic [31:0] col_o
);

  logic [31:0] sub_d, sub_q;
  logic [31:0] key_q;
  logic [31:0] mix_d, mix_q;
  logic [7:0]  a0, a1, a2, a3;
  logic [7:0]  d0, d1, d2, d3;

  // SubBytes: one table lookup per row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sub_d[8*r +: 8] = SBOX[col_i[8*r +: 8]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sub_en) begin
      sub_q <= sub_d;
      key_q <= key_i;
    end
  end

  // MixColumns plus key
  assign a0 = sub_q[7:0];
  assign a1 = sub_q[15:8];
  assign a2 = sub_q[23:16];
  assign a3 = sub_q[31:24];
  assign d0 = gf_double(a0);
  assign d1 = gf_double(a1);
  assign d2 = gf_double(a2);
  assign d3 = gf_double(a3);

  assign mix_d = {(d0 ^ a0) ^ a1 ^ a2 ^ d3,
                  a0 ^ a1 ^ d2 ^ (d3 ^ a3),
                  a0 ^ d1 ^ (d2 ^ a2) ^ a3,
                  d0 ^ (d1 ^ a1) ^ a2 ^ a3} ^ key_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mix_en) begin
      mix_q <= mix_d;
    end
  end

  assign col_o = mix_q;

endmodule

// ----- test/aes_encrypt_round_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES encryption round testbench
// Sends requests into aes_encrypt_round and checks every returned round
// against a local copy of the round. First come corner states and keys
// from a table, then random states and keys. Both channels stall in random
// bursts, with one long result hold-off and one full drain along the way.
// ----------------------------------------------------------------------------
module aes_encrypt_round_tb;
  import aesr_pkg::*;

  localparam int unsigned LATENCY     = 2;
  localparam int unsigned NUM_RANDOM  = 500;
  localparam int unsigned TAIL_ITEMS  = 60;
  localparam int unsigned LONG_HOLD   = 40;
  localparam int unsigned HOLD_AT     = 50;
  localparam int unsigned DRAIN_AT    = 250;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [7:0]  XTIME_POLY  = 8'h1b;

  // Forward S-box, kept locally so the check does not share the design's table
  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Byte values that hit the doubling carry and the S-box ends
  localparam logic [7:0] CORNER_BYTES [6] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'h52};

  // Directed row: request, result typed in where obvious, flag if typed in
  typedef struct packed {
    aesr_in_t  req;
    aesr_out_t rsp;
    logic      known;
  } dir_row_t;

  localparam int unsigned NUM_DIR = 16;
  localparam dir_row_t DIRECTED [NUM_DIR] = '{
    // all-zero state, keyless: every byte becomes 63, uniform columns mix to themselves
    '{{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      {32'h63636363, 32'h63636363, 32'h63636363, 32'h63636363}, 1'b1},
    // all-ones state, keyless
    '{{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0},
      {32'h16161616, 32'h16161616, 32'h16161616, 32'h16161616}, 1'b1},
    // zero state, all-ones key
    '{{32'h0, 32'h0, 32'h0, 32'h0,
       32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
      {32'h9c9c9c9c, 32'h9c9c9c9c, 32'h9c9c9c9c, 32'h9c9c9c9c}, 1'b1},
    // all ones everywhere
    '{{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
       32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
      {32'he9e9e9e9, 32'he9e9e9e9, 32'he9e9e9e9, 32'he9e9e9e9}, 1'b1},
    // standard round vector
    '{{32'hbee33d19, 32'h2be2f4a0, 32'h2a8dc69a, 32'h0848f8e9,
       32'h17fefaa0, 32'hb12c5488, 32'h3939a323, 32'h05766c2a}, '0, 1'b0},
    // zero state, per-column key: result is key ^ 63636363
    '{{32'h0, 32'h0, 32'h0, 32'h0,
       32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210},
      {32'h62402604, 32'heac8ae8c, 32'h9dbfd9fb, 32'h15375173}, 1'b1},
    // uniform 80 state
    '{{32'h80808080, 32'h80808080, 32'h80808080, 32'h80808080, 32'h0, 32'h0, 32'h0, 32'h0},
      {32'hcdcdcdcd, 32'hcdcdcdcd, 32'hcdcdcdcd, 32'hcdcdcdcd}, 1'b1},
    // 52 maps to zero, so the result is the key itself
    '{{32'h52525252, 32'h52525252, 32'h52525252, 32'h52525252,
       32'ha5a5a5a5, 32'h5a5a5a5a, 32'hffff0000, 32'h0000ffff},
      {32'ha5a5a5a5, 32'h5a5a5a5a, 32'hffff0000, 32'h0000ffff}, 1'b1},
    // distinct bytes expose the row shifts
    '{{32'h03020100, 32'h07060504, 32'h0b0a0908, 32'h0f0e0d0c, 32'h0, 32'h0, 32'h0, 32'h0},
      '0, 1'b0},
    '{{32'h03020100, 32'h07060504, 32'h0b0a0908, 32'h0f0e0d0c,
       32'h0f1e2d3c, 32'h4b5a6978, 32'h8796a5b4, 32'hc3d2e1f0}, '0, 1'b0},
    // alternating bit patterns
    '{{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
       32'h5a5a5a5a, 32'ha5a5a5a5, 32'h5a5a5a5a, 32'ha5a5a5a5}, '0, 1'b0},
    // lone bytes in the lowest and highest rows
    '{{32'h00000080, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, '0, 1'b0},
    '{{32'h0, 32'h0, 32'h0, 32'hff000000, 32'h0, 32'h0, 32'h0, 32'h0}, '0, 1'b0},
    // walking ones across rows and columns
    '{{32'h80402010, 32'h08040201, 32'h01020408, 32'h10204080, 32'h0, 32'h0, 32'h0, 32'h0},
      '0, 1'b0},
    '{{32'h7f7f7f7f, 32'hfefefefe, 32'h7f80ff00, 32'h00ff807f,
       32'h80000001, 32'h00800100, 32'h01000080, 32'h80808080}, '0, 1'b0},
    // keyless round of a counting state
    '{{32'h33221100, 32'h77665544, 32'hbbaa9988, 32'hffeeddcc, 32'h0, 32'h0, 32'h0, 32'h0},
      '0, 1'b0}
  };

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  aesr_in_t  in_req_i    = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  aesr_out_t out_rsp_o;

  aesr_out_t   offered_rsp = '0;   // expected result of the request on the bus
  aesr_out_t   expected_rounds [$];
  aesr_out_t   oldest_round;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct     = 0;
  bit          long_hold_req = 1'b0;

  aes_encrypt_round dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? XTIME_POLY : 8'h00);
  endfunction

  // SubBytes, ShiftRows, MixColumns, then the round key
  function automatic aesr_out_t predict_round(input aesr_in_t req);
    logic [31:0] st [4];
    logic [31:0] rk [4];
    logic [31:0] col [4];
    logic [7:0]  a0, a1, a2, a3;
    logic [7:0]  d0, d1, d2, d3;
    aesr_out_t   rsp;
    st = '{req.state_col0, req.state_col1, req.state_col2, req.state_col3};
    rk = '{req.key_col0, req.key_col1, req.key_col2, req.key_col3};
    for (int c = 0; c < 4; c++) begin
      // row r of output column c comes from input column c + r
      a0 = FWD_SBOX[st[c][7:0]];
      a1 = FWD_SBOX[st[(c + 1) % 4][15:8]];
      a2 = FWD_SBOX[st[(c + 2) % 4][23:16]];
      a3 = FWD_SBOX[st[(c + 3) % 4][31:24]];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      col[c] = {d0 ^ a0 ^ a1 ^ a2 ^ d3,
                a0 ^ a1 ^ d2 ^ d3 ^ a3,
                a0 ^ d1 ^ d2 ^ a2 ^ a3,
                d0 ^ d1 ^ a1 ^ a2 ^ a3} ^ rk[c];
    end
    rsp.out_col0 = col[0];
    rsp.out_col1 = col[1];
    rsp.out_col2 = col[2];
    rsp.out_col3 = col[3];
    return rsp;
  endfunction

  // Mostly full random words; some keyless rounds and some corner-byte states
  function automatic aesr_in_t random_request();
    aesr_in_t    req;
    logic [31:0] words [8];
    int unsigned kind;
    kind = $urandom_range(9);
    for (int w = 0; w < 8; w++) begin
      words[w] = $urandom();
    end
    if (kind == 1) begin
      for (int w = 0; w < 4; w++) begin
        for (int b = 0; b < 4; b++) begin
          words[w][8*b +: 8] = CORNER_BYTES[$urandom_range(5)];
        end
      end
    end
    if (kind <= 1 && $urandom_range(1) == 1) begin
      for (int w = 4; w < 8; w++) begin
        words[w] = '0;
      end
    end
    req = {words[0], words[1], words[2], words[3],
           words[4], words[5], words[6], words[7]};
    return req;
  endfunction

  // Put one request on the bus and hold it until accepted
  task automatic offer(input aesr_in_t req, input aesr_out_t rsp);
    in_valid_i  <= 1'b1;
    in_req_i    <= req;
    offered_rsp <= rsp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic rest_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_rounds.size() != 0);
  endtask

  task automatic check_col(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Request side
  initial begin
    aesr_in_t req;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 30;
    for (int i = 0; i < NUM_DIR; i++) begin
      if ($urandom_range(99) < idle_pct) rest_input($urandom_range(1, 11));
      offer(DIRECTED[i].req,
            DIRECTED[i].known ? DIRECTED[i].rsp : predict_round(DIRECTED[i].req));
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // idle level changes by phase; none at all near the end
      if (i >= NUM_RANDOM - TAIL_ITEMS) idle_pct = 0;
      else begin
        case ((i / 110) % 4)
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          2:       idle_pct = 50;
          default: idle_pct = 10;
        endcase
      end
      // long result hold-off while requests keep coming back to back
      if (i == HOLD_AT) long_hold_req = 1'b1;
      if (i == DRAIN_AT) drain_results();
      if ($urandom_range(99) < idle_pct) rest_input($urandom_range(1, 11));
      req = random_request();
      offer(req, predict_round(req));
    end

    drain_results();
    repeat (4 * LATENCY) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side back-pressure
  initial begin
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if ($urandom_range(99) < idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Record accepted requests, compare accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_rounds.push_back(offered_rsp);
      if (out_valid_o && out_ready_i) begin
        if (expected_rounds.size() == 0) begin
          $error("unexpected result %h", out_rsp_o);
          mismatch_cnt++;
        end else begin
          oldest_round = expected_rounds.pop_front();
          check_col("out_col0", oldest_round.out_col0, out_rsp_o.out_col0);
          check_col("out_col1", oldest_round.out_col1, out_rsp_o.out_col1);
          check_col("out_col2", oldest_round.out_col2, out_rsp_o.out_col2);
          check_col("out_col3", oldest_round.out_col3, out_rsp_o.out_col3);
        end
      end
    end
  end

  // Watchdog: too long without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
